/* design/bdl_pkg.sv */
package bdl_pkg;

   typedef enum logic [2:0] {
      ACT_INS_HEAD = 3'd0,
      ACT_INS_TAIL = 3'd1,
      ACT_RM_HEAD  = 3'd2,
      ACT_RM_TAIL  = 3'd3,
      ACT_RD_HEAD  = 3'd4,
      ACT_RD_TAIL  = 3'd5,
      ACT_RD_INDEX = 3'd6,
      ACT_REVERSE  = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      action_type         action;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         symbol;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic [7:0]         out_symbol;
      status_type         status;
      logic [8:0]         count;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [7:0]         sym;
   } entry_type;

endpackage

/* design/bdl_store.sv */
module bdl_store #(
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  bdl_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output bdl_pkg::entry_type rd_data
);
   import bdl_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bounded_deque_list_core.sv */
// bounded deque of (x, y, symbol) entries in a circular store with head slot and direction
// a beat accepted into the s1 register raises rsp_valid when it advances into the result registers
// throughput: one beat per cycle unless rsp_ready stalls it; store has one write and one registered read port
// each action touches at most one store slot, so back-to-back beats see each other's updates
// reset: synchronous, clears count, head slot, direction and both pipeline valids
// store contents are not cleared; a slot's data is only returned after it has been written
module bounded_deque_list_core #(
   parameter int CAPACITY = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bdl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdl_pkg::rsp_type rsp_data
);
   import bdl_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 8) ? CW : 8;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] s, input logic [AW-1:0] k);
      logic [AW:0] sum;
      sum = {1'b0, s} + {1'b0, k};
      if (sum >= (AW+1)'(CAPACITY)) begin
         sum = sum - (AW+1)'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] s, input logic [AW-1:0] k);
      logic [AW:0] dif;
      if (s >= k) begin
         dif = {1'b0, s} - {1'b0, k};
      end else begin
         dif = {1'b0, s} + (AW+1)'(CAPACITY) - {1'b0, k};
      end
      return dif[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] start, input logic rev,
                                          input logic [AW-1:0] k);
      return rev ? wrap_sub(start, k) : wrap_add(start, k);
   endfunction

   // pipeline control
   logic    s1_valid_ff;
   req_type s1_req_ff;
   logic    rsp_valid_ff;
   logic    advance;

   // list state
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] start_ff, start_in;
   logic          rev_ff, rev_in;

   // result register
   status_type    status_ff, status_in;
   logic [CW-1:0] rsp_count_ff;
   logic          have_ff, have_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;

   logic          full, empty;
   logic [CW-1:0] count_m1;
   logic [XW-1:0] pos_ext;
   logic [AW-1:0] head_prev, head_next;

   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         start_ff     <= '0;
         rev_ff       <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
            start_ff     <= start_in;
            rev_ff       <= rev_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
         have_ff      <= have_in;
      end
   end

   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign count_m1  = count_ff - CW'(1);
   assign pos_ext   = XW'(s1_req_ff.position);
   assign head_prev = rev_ff ? wrap_add(start_ff, AW'(1)) : wrap_sub(start_ff, AW'(1));
   assign head_next = rev_ff ? wrap_sub(start_ff, AW'(1)) : wrap_add(start_ff, AW'(1));

   assign wr_data = '{x: s1_req_ff.pos_x, y: s1_req_ff.pos_y, sym: s1_req_ff.symbol};

   always_comb begin
      count_in  = count_ff;
      start_in  = start_ff;
      rev_in    = rev_ff;
      status_in = ST_DONE;
      have_in   = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = start_ff;
      rd_addr   = start_ff;
      case (s1_req_ff.action)
         ACT_INS_HEAD: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               start_in = head_prev;
               wr_en    = 1'b1;
               wr_addr  = head_prev;
               count_in = count_ff + CW'(1);
            end
         end
         ACT_INS_TAIL: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = phys(start_ff, rev_ff, count_ff[AW-1:0]);
               count_in = count_ff + CW'(1);
            end
         end
         ACT_RM_HEAD: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               start_in = head_next;
               count_in = count_m1;
            end
         end
         ACT_RM_TAIL: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_m1;
            end
         end
         ACT_RD_HEAD: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               have_in = 1'b1;
            end
         end
         ACT_RD_TAIL: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               have_in = 1'b1;
               rd_addr = phys(start_ff, rev_ff, count_m1[AW-1:0]);
            end
         end
         ACT_RD_INDEX: begin
            if (pos_ext >= XW'(count_ff)) begin
               status_in = ST_RANGE;
            end else begin
               have_in = 1'b1;
               rd_addr = phys(start_ff, rev_ff, pos_ext[AW-1:0]);
            end
         end
         ACT_REVERSE: begin
            if (count_ff > CW'(1)) begin
               start_in = phys(start_ff, rev_ff, count_m1[AW-1:0]);
               rev_in   = ~rev_ff;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   assign rd_en = advance;

   bdl_store #(
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en & advance),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.out_x      = have_ff ? rd_data.x : '0;
   assign rsp_data.out_y      = have_ff ? rd_data.y : '0;
   assign rsp_data.out_symbol = have_ff ? rd_data.sym : '0;
   assign rsp_data.status     = status_ff;
   assign rsp_data.count      = 9'(rsp_count_ff);

endmodule

/* design/bdl_checker.sv */
module bdl_checker #(
   parameter int CAPACITY = 256
) (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bdl_pkg::rsp_type rsp_data
);
   import bdl_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // data only on successful reads
   a_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |->
         rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_symbol == '0)
      else $error("data on a failed action");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.count == '0)
      else $error("empty status with nonzero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.count == 9'(CAPACITY))
      else $error("full status below capacity");

   // with no result waiting the input side is open
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with no result waiting");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind bounded_deque_list_core bdl_checker #(.CAPACITY(CAPACITY)) u_bdl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
